// ===== src/csv_line_field_splitter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef CSV_LINE_FIELD_SPLITTER_DEFINES_SVH
`define CSV_LINE_FIELD_SPLITTER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define CSVFS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("csvfs assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define CSVFS_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("csvfs implication failed");

// Check that a condition implies a consequence in the next cycle.
`define CSVFS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("csvfs next-cycle check failed");

`endif

// ===== src/csvfs_pkg.sv =====
package csvfs_pkg;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	localparam int COL_OUT_W = 6;
	localparam int POS_OUT_W = 7;
	localparam int CNT_OUT_W = 6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

endpackage

// ===== src/csv_line_field_splitter.sv =====
// CSV line field splitter.
// Input channel (in_valid/in_ready): one item per byte of a CSV line, text_byte
// plus end_of_text; an item with end_of_text set closes the line and clears all
// parser state, and its text_byte is ignored.
// Output channel (out_valid/out_ready): zero or one result item per input item:
// a stored field byte, a field close at an unquoted comma within the column
// limit, a line-done item with the cell count, or a malformed-quote error.
// Output: a result is loaded into the output register and appears in the cycle
// after its input item is accepted. Throughput: one item per cycle while in_ready
// is high; the parser state is a handful of flip-flops updated by a single pass of logic per byte.
// Stall: in_ready drops only while a result sits in the output register and
// out_ready is low, so the output register acts as the single buffer stage.
// Items that cause no result still pass at full rate.
// Reset: arst_n clears the parser state and empties the output register.
// Quoted fields keep commas, CR and LF; a doubled quote stores one quote byte.
// A quote seen inside quotes is held as pending and settled by the next byte.
module csv_line_field_splitter #(
	parameter int MAX_COLUMNS   = 32,
	parameter int CELL_CAPACITY = 72
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            text_byte,
	input  logic                                  end_of_text,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output csvfs_pkg::kind_t                      result_kind,
	output logic [csvfs_pkg::COL_OUT_W-1:0]       column_index,
	output logic [csvfs_pkg::POS_OUT_W-1:0]       byte_position,
	output logic [7:0]                            field_byte,
	output logic [csvfs_pkg::CNT_OUT_W-1:0]       field_total
);
	import csvfs_pkg::*;

	// Column counter holds 0..MAX_COLUMNS, position counter 0..CELL_CAPACITY-1.
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int PW = $clog2(CELL_CAPACITY);
	localparam logic [CW-1:0] MAX_COL_C = CW'(MAX_COLUMNS);
	localparam logic [PW-1:0] POS_LIMIT = PW'(CELL_CAPACITY - 1);

	// Parser state.
	logic          inside_quotes_q, quote_was_closed_q, quote_pending_q;
	logic          line_finished_q, line_failed_q;
	logic [CW-1:0] current_column_q;
	logic [PW-1:0] current_position_q;

	logic          inside_quotes_d, quote_was_closed_d, quote_pending_d;
	logic          line_finished_d, line_failed_d;
	logic [CW-1:0] current_column_d;
	logic [PW-1:0] current_position_d;

	// Result of the byte at the input.
	logic          emit;
	kind_t         emit_kind;
	logic [CW-1:0] emit_col;
	logic [PW-1:0] emit_pos;
	logic [7:0]    emit_byte;
	logic [CW-1:0] emit_cnt;

	// Output register.
	logic                 out_valid_q;
	kind_t                result_kind_q;
	logic [COL_OUT_W-1:0] column_index_q;
	logic [POS_OUT_W-1:0] byte_position_q;
	logic [7:0]           field_byte_q;
	logic [CNT_OUT_W-1:0] field_total_q;

	// Zero-extend, then truncate to the port widths.
	logic [CW+COL_OUT_W-1:0] col_ext;
	logic [PW+POS_OUT_W-1:0] pos_ext;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	logic accept;
	logic take;
	logic do_store;
	logic is_cr_lf;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_cr_lf = (text_byte == CH_CR) || (text_byte == CH_LF);

	always_comb begin
		inside_quotes_d    = inside_quotes_q;
		quote_was_closed_d = quote_was_closed_q;
		quote_pending_d    = quote_pending_q;
		line_finished_d    = line_finished_q;
		line_failed_d      = line_failed_q;
		current_column_d   = current_column_q;
		current_position_d = current_position_q;
		emit      = 1'b0;
		emit_kind = KIND_BYTE;
		emit_col  = current_column_q;
		emit_pos  = current_position_q;
		emit_byte = 8'd0;
		emit_cnt  = '0;
		take      = 1'b0;
		do_store  = 1'b0;

		if (end_of_text) begin
			// Report the line unless it failed, then clear everything.
			emit      = !line_failed_q;
			emit_kind = KIND_DONE;
			emit_cnt  = (current_column_q < MAX_COL_C) ? current_column_q + CW'(1)
			                                           : current_column_q;
			inside_quotes_d    = 1'b0;
			quote_was_closed_d = 1'b0;
			quote_pending_d    = 1'b0;
			line_finished_d    = 1'b0;
			line_failed_d      = 1'b0;
			current_column_d   = '0;
			current_position_d = '0;
		end else if (!line_finished_q) begin
			take = 1'b1;
			if (quote_pending_q) begin
				// Settle the pending quote: doubled quote or closing quote.
				quote_pending_d = 1'b0;
				if (text_byte == CH_QUOTE) begin
					do_store = 1'b1;
					take     = 1'b0;
				end else begin
					inside_quotes_d    = 1'b0;
					quote_was_closed_d = 1'b1;
				end
			end

			if (take) begin
				priority if (!inside_quotes_d && is_cr_lf) begin
					line_finished_d = 1'b1;
				end else if (current_column_q >= MAX_COL_C) begin
					line_finished_d = 1'b1;
				end else if (inside_quotes_d) begin
					if (text_byte == CH_QUOTE) begin
						quote_pending_d = 1'b1;
					end else begin
						do_store = 1'b1;
					end
				end else if (text_byte == CH_COMMA) begin
					emit               = 1'b1;
					emit_kind          = KIND_CLOSE;
					current_column_d   = current_column_q + CW'(1);
					current_position_d = '0;
					quote_was_closed_d = 1'b0;
				end else if (text_byte == CH_QUOTE && current_position_q == '0
				             && !quote_was_closed_d) begin
					inside_quotes_d = 1'b1;
				end else if (quote_was_closed_d) begin
					// Only blanks may follow a closing quote.
					if (text_byte != CH_SPACE && text_byte != CH_TAB) begin
						line_finished_d = 1'b1;
						line_failed_d   = 1'b1;
						emit            = 1'b1;
						emit_kind       = KIND_ERROR;
					end
				end else begin
					do_store = 1'b1;
				end
			end

			// Store into the field unless it is full; drop the byte otherwise.
			if (do_store && current_position_q < POS_LIMIT) begin
				emit               = 1'b1;
				emit_kind          = KIND_BYTE;
				emit_byte          = text_byte;
				current_position_d = current_position_q + PW'(1);
			end
		end
	end

	always_comb begin
		col_ext = {{COL_OUT_W{1'b0}}, emit_col};
		pos_ext = {{POS_OUT_W{1'b0}}, emit_pos};
		cnt_ext = {{CNT_OUT_W{1'b0}}, emit_cnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_quotes_q    <= 1'b0;
			quote_was_closed_q <= 1'b0;
			quote_pending_q    <= 1'b0;
			line_finished_q    <= 1'b0;
			line_failed_q      <= 1'b0;
			current_column_q   <= '0;
			current_position_q <= '0;
		end else if (accept) begin
			inside_quotes_q    <= inside_quotes_d;
			quote_was_closed_q <= quote_was_closed_d;
			quote_pending_q    <= quote_pending_d;
			line_finished_q    <= line_finished_d;
			line_failed_q      <= line_failed_d;
			current_column_q   <= current_column_d;
			current_position_q <= current_position_d;
		end
	end

	// Load the output register on accept; drain it when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			result_kind_q   <= emit_kind;
			column_index_q  <= col_ext[COL_OUT_W-1:0];
			byte_position_q <= pos_ext[POS_OUT_W-1:0];
			field_byte_q    <= emit_byte;
			field_total_q   <= cnt_ext[CNT_OUT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = result_kind_q;
	assign column_index  = column_index_q;
	assign byte_position = byte_position_q;
	assign field_byte    = field_byte_q;
	assign field_total   = field_total_q;

endmodule

// ===== src/csvfs_checker.sv =====
`include "csv_line_field_splitter_defines.svh"

module csvfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             end_of_text,
	input logic                             out_valid,
	input logic                             out_ready,
	input csvfs_pkg::kind_t                 result_kind,
	input logic [csvfs_pkg::COL_OUT_W-1:0]  column_index,
	input logic [csvfs_pkg::POS_OUT_W-1:0]  byte_position,
	input logic [7:0]                       field_byte,
	input logic [csvfs_pkg::CNT_OUT_W-1:0]  field_total
);
	import csvfs_pkg::*;

	logic [2+COL_OUT_W+POS_OUT_W+8+CNT_OUT_W-1:0] out_word;
	logic                                         out_stalled;
	logic                                         end_taken;
	logic                                         fields_zero_ok;

	assign out_word    = {result_kind, column_index, byte_position, field_byte, field_total};
	assign out_stalled = out_valid && !out_ready;
	assign end_taken   = in_valid && in_ready && end_of_text;
	assign fields_zero_ok = (result_kind == KIND_BYTE || field_byte == 8'd0)
		&& (result_kind == KIND_DONE || field_total == '0);

	// A stalled result holds.
	`CSVFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stalled, out_valid && $stable(out_word))
	// Only a waiting result blocks the input.
	`CSVFS_ASSERT_IMPL(a_ready_stall, clk, arst_n, !in_ready, out_stalled)
	// An end marker gives a done item or nothing.
	`CSVFS_ASSERT_NEXT(a_end_done, clk, arst_n, end_taken, !out_valid || result_kind == KIND_DONE)
	// Byte and count fields are zero outside their kinds.
	`CSVFS_ASSERT_IMPL(a_zero_fields, clk, arst_n, out_valid, fields_zero_ok)

endmodule

bind csv_line_field_splitter csvfs_checker u_csvfs_checker (.*);

// ===== tb/tb_csv_line_field_splitter.sv =====
module tb_csv_line_field_splitter;
	import csvfs_pkg::*;

	// Block sizes under test; they match the defaults of the splitter.
	localparam int MAX_COLS     = 32;
	localparam int CELL_CAP     = 72;
	// Stop the random phase once this many non-ignored items have gone in.
	localparam int RANDOM_ITEMS = 1000;
	// Longest idle draw per item on either side.
	localparam int IDLE_MAX     = 19;

	// One result item as the output channel presents it.
	typedef struct packed {
		kind_t                kind;
		logic [COL_OUT_W-1:0] col;
		logic [POS_OUT_W-1:0] pos;
		logic [7:0]           fbyte;
		logic [CNT_OUT_W-1:0] cnt;
	} split_res_t;

	// One row of the directed stimulus; typed rows carry their own expected result.
	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       typed;
		split_res_t res;
	} text_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           text_byte;
	logic                 end_of_text;
	logic                 out_valid;
	logic                 out_ready;
	kind_t                result_kind;
	logic [COL_OUT_W-1:0] column_index;
	logic [POS_OUT_W-1:0] byte_position;
	logic [7:0]           field_byte;
	logic [CNT_OUT_W-1:0] field_total;

	csv_line_field_splitter #(
		.MAX_COLUMNS  (MAX_COLS),
		.CELL_CAPACITY(CELL_CAP)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.column_index (column_index),
		.byte_position(byte_position),
		.field_byte   (field_byte),
		.field_total  (field_total)
	);

	// Shadow copy of the parser state, advanced once per accepted item.
	logic                 in_quote;
	logic                 closed_seen;
	logic                 quote_wait;
	logic                 line_halted;
	logic                 line_bad;
	logic [COL_OUT_W-1:0] cur_col;
	logic [POS_OUT_W-1:0] cur_pos;

	// Results the splitter still owes, oldest first.
	split_res_t split_results_due [$];
	// Bytes of the line being sent: {end_of_text, text_byte}.
	logic [8:0] line_items [$];

	int mismatches;
	int sent_items;
	int send_run;
	int recv_run;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic clear_split_state();
		in_quote     = 1'b0;
		closed_seen  = 1'b0;
		quote_wait   = 1'b0;
		line_halted  = 1'b0;
		line_bad     = 1'b0;
		cur_col      = '0;
		cur_pos      = '0;
	endtask

	// Store one byte into the current field, unless the field is full.
	task automatic store_field_byte(input logic [7:0] ch, inout bit got,
			inout split_res_t r);
		if (int'(cur_pos) + 1 < CELL_CAP) begin
			got     = 1'b1;
			r.kind  = KIND_BYTE;
			r.col   = cur_col;
			r.pos   = cur_pos;
			r.fbyte = ch;
			cur_pos = cur_pos + 1'b1;
		end
	endtask

	// Work out the result, if any, that one accepted item causes.
	task automatic predict_split(input logic [7:0] ch, input logic eot, output bit got,
			output split_res_t r);
		got = 1'b0;
		r   = '0;
		if (eot) begin
			// A line that failed on a quote gives no done item.
			if (!line_bad) begin
				got    = 1'b1;
				r.kind = KIND_DONE;
				r.col  = cur_col;
				r.pos  = cur_pos;
				r.cnt  = (cur_col < MAX_COLS) ? cur_col + 6'd1 : cur_col;
			end
			clear_split_state();
		end else if (!line_halted) begin
			if (quote_wait && ch == CH_QUOTE) begin
				// Doubled quote inside quotes: one quote byte of data.
				quote_wait = 1'b0;
				store_field_byte(CH_QUOTE, got, r);
			end else begin
				if (quote_wait) begin
					// The held quote was the closing one.
					quote_wait   = 1'b0;
					in_quote     = 1'b0;
					closed_seen  = 1'b1;
				end
				if (!in_quote && (ch == CH_CR || ch == CH_LF)) begin
					line_halted = 1'b1;
				end else if (cur_col >= MAX_COLS) begin
					line_halted = 1'b1;
				end else if (in_quote) begin
					if (ch == CH_QUOTE)
						quote_wait = 1'b1;
					else
						store_field_byte(ch, got, r);
				end else if (ch == CH_COMMA) begin
					got          = 1'b1;
					r.kind       = KIND_CLOSE;
					r.col        = cur_col;
					r.pos        = cur_pos;
					cur_col      = cur_col + 1'b1;
					cur_pos      = '0;
					closed_seen  = 1'b0;
				end else if (ch == CH_QUOTE && cur_pos == 0 && !closed_seen) begin
					in_quote = 1'b1;
				end else if (closed_seen) begin
					// Only blanks may follow a closing quote.
					if (ch != CH_SPACE && ch != CH_TAB) begin
						line_halted = 1'b1;
						line_bad    = 1'b1;
						got         = 1'b1;
						r.kind      = KIND_ERROR;
						r.col       = cur_col;
						r.pos       = cur_pos;
					end
				end else begin
					store_field_byte(ch, got, r);
				end
			end
		end
	endtask

	// Draw the idle cycles before the next item; runs of zero give stretches at full rate.
	task automatic draw_wait(inout int run_left, output int cycles);
		if (run_left > 0) begin
			run_left--;
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, IDLE_MAX);
			if ($urandom_range(0, 29) == 0)
				run_left = $urandom_range(10, 40);
		end
	endtask

	// Offer one item, hold it until accepted, then record what it should cause.
	task automatic put_item(input logic [7:0] ch, input logic eot, input logic typed,
			input split_res_t typed_res);
		int         gap;
		bit         got;
		split_res_t r;
		draw_wait(send_run, gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_byte   <= ch;
		end_of_text <= eot;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		// Bytes after a finished line are ignored and do not count.
		if (eot || !line_halted)
			sent_items++;
		predict_split(ch, eot, got, r);
		if (typed)
			split_results_due.push_back(typed_res);
		else if (got)
			split_results_due.push_back(r);
	endtask

	// Hold the input idle until every owed result has come out.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (split_results_due.size() != 0) @(posedge clk);
	endtask

	function automatic text_row_t text_row(input logic [7:0] ch, input logic eot,
			input logic typed, input kind_t kind, input int col, input int pos,
			input int fb, input int cnt);
		text_row_t t;
		t.ch        = ch;
		t.eot       = eot;
		t.typed     = typed;
		t.res.kind  = kind;
		t.res.col   = COL_OUT_W'(col);
		t.res.pos   = POS_OUT_W'(pos);
		t.res.fbyte = 8'(fb);
		t.res.cnt   = CNT_OUT_W'(cnt);
		return t;
	endfunction

	// Ordinary field byte: mostly printable, sometimes any byte but the separators.
	function automatic logic [7:0] pick_plain_byte();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0)
			b = 8'($urandom_range(0, 255));
		else
			b = 8'($urandom_range(32'h20, 32'h7E));
		if (b == CH_COMMA || b == CH_CR || b == CH_LF)
			b = 8'h5F;
		return b;
	endfunction

	// Build one random line into line_items, ending with the end marker.
	task automatic build_line();
		int         style;
		int         n_fields;
		int         len_hi;
		int         len;
		int         field_sel;
		logic [7:0] b;
		bit         open_end;
		line_items.delete();
		style = $urandom_range(0, 19);
		if (style < 2) begin
			// Noise: arbitrary bytes with plenty of quotes.
			len = $urandom_range(0, 12);
			repeat (len) begin
				if ($urandom_range(0, 3) == 0)
					b = CH_QUOTE;
				else
					b = 8'($urandom_range(0, 255));
				line_items.push_back({1'b0, b});
			end
		end else begin
			n_fields = $urandom_range(1, 6);
			len_hi   = 6;
			if (style == 2) begin
				// Wide line: short fields, at times running past the column limit.
				n_fields = $urandom_range(30, 36);
				len_hi   = 2;
			end else if (style == 3) begin
				// Long fields: lengths near and past the field capacity.
				n_fields = $urandom_range(1, 2);
			end
			for (int f = 0; f < n_fields; f++) begin
				if (f != 0)
					line_items.push_back({1'b0, CH_COMMA});
				len = (style == 3) ? $urandom_range(60, 80) : $urandom_range(0, len_hi);
				field_sel = $urandom_range(0, 19);
				if (field_sel < 11) begin
					repeat (len) line_items.push_back({1'b0, pick_plain_byte()});
				end else begin
					line_items.push_back({1'b0, CH_QUOTE});
					repeat (len) begin
						case ($urandom_range(0, 7))
							0: line_items.push_back({1'b0, CH_COMMA});
							1: line_items.push_back({1'b0, CH_CR});
							2: line_items.push_back({1'b0, CH_LF});
							3: begin
								line_items.push_back({1'b0, CH_QUOTE});
								line_items.push_back({1'b0, CH_QUOTE});
							end
							default: line_items.push_back({1'b0, pick_plain_byte()});
						endcase
					end
					// Leave the last quoted field open now and then.
					open_end = (f == n_fields - 1) && ($urandom_range(0, 5) == 0);
					if (!open_end) begin
						line_items.push_back({1'b0, CH_QUOTE});
						if (field_sel >= 17) begin
							repeat ($urandom_range(1, 3)) begin
								b = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
								line_items.push_back({1'b0, b});
							end
						end
						if (field_sel == 19) begin
							b = 8'($urandom_range(0, 255));
							if (b == CH_SPACE || b == CH_TAB || b == CH_COMMA ||
									b == CH_CR || b == CH_LF)
								b = 8'h78;
							line_items.push_back({1'b0, b});
						end
					end
				end
			end
			case ($urandom_range(0, 9))
				0: begin
					line_items.push_back({1'b0, CH_CR});
					line_items.push_back({1'b0, CH_LF});
				end
				1: line_items.push_back({1'b0, CH_LF});
				2: begin
					// Trailing junk after the line break must be ignored.
					line_items.push_back({1'b0, CH_CR});
					repeat ($urandom_range(1, 4))
						line_items.push_back({1'b0, 8'($urandom_range(0, 255))});
				end
				default: ;
			endcase
		end
		line_items.push_back({1'b1, 8'($urandom_range(0, 255))});
	endtask

	// Stimulus: reset, directed table, random lines, drain.
	initial begin
		text_row_t  dir_rows [$];
		split_res_t no_res;
		logic [8:0] it;
		int         lines;
		no_res      = '0;
		mismatches  = 0;
		sent_items  = 0;
		send_run    = 0;
		lines       = 0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		text_byte   <= '0;
		end_of_text <= 1'b0;
		clear_split_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// End marker straight after reset: one empty cell.
		dir_rows.push_back(text_row(8'hFF, 1'b1, 1'b1, KIND_DONE, 0, 0, 0, 1));
		dir_rows.push_back(text_row(8'h61, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_COMMA, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		// Quoted field with a comma, a doubled quote and a CR as data.
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_COMMA, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_CR, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		// Blanks after the closing quote are dropped, anything else is an error.
		dir_rows.push_back(text_row(CH_SPACE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_TAB, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(8'h78, 1'b0, 1'b1, KIND_ERROR, 1, 3, 0, 0));
		dir_rows.push_back(text_row(8'h79, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		// A failed line closes silently.
		dir_rows.push_back(text_row(8'h00, 1'b1, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		// Byte extremes, then a quote in mid field kept as data.
		dir_rows.push_back(text_row(8'h00, 1'b0, 1'b1, KIND_BYTE, 0, 0, 8'h00, 0));
		dir_rows.push_back(text_row(8'hFF, 1'b0, 1'b1, KIND_BYTE, 0, 1, 8'hFF, 0));
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		// Unquoted LF ends the line; later bytes are ignored.
		dir_rows.push_back(text_row(CH_LF, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(8'h7A, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(8'hFF, 1'b1, 1'b1, KIND_DONE, 0, 3, 0, 1));
		// Quote right before the end marker.
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(8'h71, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(8'h55, 1'b1, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		// Quoted field never closed.
		dir_rows.push_back(text_row(CH_QUOTE, 1'b0, 1'b0, KIND_BYTE, 0, 0, 0, 0));
		dir_rows.push_back(text_row(8'hAA, 1'b1, 1'b0, KIND_BYTE, 0, 0, 0, 0));

		foreach (dir_rows[i])
			put_item(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].res);

		// Let the output side empty before the random phase.
		pause_until_drained();
		sent_items = 0;

		while (sent_items < RANDOM_ITEMS) begin
			build_line();
			foreach (line_items[i]) begin
				it = line_items[i];
				put_item(it[7:0], it[8], 1'b0, no_res);
			end
			lines++;
			if (lines % 8 == 0 && $urandom_range(0, 3) == 0)
				pause_until_drained();
		end

		pause_until_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Result side: random stalls, then compare each item with the oldest owed result.
	initial begin
		int         gap;
		split_res_t want;
		recv_run = 0;
		out_ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			draw_wait(recv_run, gap);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (split_results_due.size() == 0) begin
				$error("unexpected result item: kind %0d col %0d pos %0d",
					result_kind, column_index, byte_position);
				mismatches++;
			end else begin
				want = split_results_due.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, got %0d", want.kind, result_kind);
					mismatches++;
				end
				if (column_index !== want.col) begin
					$error("column_index: expected %0d, got %0d", want.col, column_index);
					mismatches++;
				end
				if (byte_position !== want.pos) begin
					$error("byte_position: expected %0d, got %0d", want.pos, byte_position);
					mismatches++;
				end
				if (field_byte !== want.fbyte) begin
					$error("field_byte: expected %0h, got %0h", want.fbyte, field_byte);
					mismatches++;
				end
				if (field_total !== want.cnt) begin
					$error("field_total: expected %0d, got %0d", want.cnt, field_total);
					mismatches++;
				end
			end
		end
	end

endmodule

// ===== sim.f =====
+incdir+src
src/csvfs_pkg.sv
src/csv_line_field_splitter.sv
src/csvfs_checker.sv
tb/tb_csv_line_field_splitter.sv
